// File: hdl/hpt_pkg.sv
`default_nettype none
package hpt_pkg;

  // Configuration register indexes
  localparam logic [3:0] REG_ROW0_XY = 4'd0;
  localparam logic [3:0] REG_ROW0_ZW = 4'd1;
  localparam logic [3:0] REG_ROW1_XY = 4'd2;
  localparam logic [3:0] REG_ROW1_ZW = 4'd3;
  localparam logic [3:0] REG_ROW2_XY = 4'd4;
  localparam logic [3:0] REG_ROW2_ZW = 4'd5;
  localparam logic [3:0] REG_ROW3_XY = 4'd6;
  localparam logic [3:0] REG_ROW3_ZW = 4'd7;

  localparam int unsigned NUM_REGS = 8;

  // Transform kinds
  localparam logic [1:0] KIND_POST_POINT  = 2'd0;
  localparam logic [1:0] KIND_PRE_POINT   = 2'd1;
  localparam logic [1:0] KIND_POST_VECTOR = 2'd2;
  localparam logic [1:0] KIND_PRE_VECTOR  = 2'd3;

  // Identity matrix in Q16.16
  localparam logic [63:0] ROW0_XY_RST = 64'h0000_0000_0001_0000;
  localparam logic [63:0] ROW0_ZW_RST = 64'h0000_0000_0000_0000;
  localparam logic [63:0] ROW1_XY_RST = 64'h0001_0000_0000_0000;
  localparam logic [63:0] ROW1_ZW_RST = 64'h0000_0000_0000_0000;
  localparam logic [63:0] ROW2_XY_RST = 64'h0000_0000_0000_0000;
  localparam logic [63:0] ROW2_ZW_RST = 64'h0000_0000_0001_0000;
  localparam logic [63:0] ROW3_XY_RST = 64'h0000_0000_0000_0000;
  localparam logic [63:0] ROW3_ZW_RST = 64'h0001_0000_0000_0000;

  typedef logic signed [31:0] coef_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [65:0] dot_t;

endpackage
`default_nettype wire

// File: hdl/hpt_div.sv
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage, magnitudes only.
module hpt_div
  import hpt_pkg::*;
#(
  parameter int CW = 32,
  parameter int F  = 16
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic [CW+F-1:0]    num_i,
  input  wire logic [CW-1:0]      den_i,
  input  wire logic               neg_i,
  output logic      [CW-1:0]      quo_o,
  output logic                    ovf_o,
  output logic                    neg_o
);

  localparam int NW = CW + F;

  logic [CW-1:0] rem_q [CW+1];
  logic [CW-1:0] low_q [CW+1];
  logic [CW-1:0] quo_q [CW+1];
  logic [CW-1:0] den_q [CW+1];
  logic          ovf_q [CW+1];
  logic          neg_q [CW+1];

  logic [CW-1:0] rem_d [CW];
  logic [CW-1:0] quo_d [CW];

  logic [F-1:0]  num_hi;
  logic          ovf0;

  assign num_hi = num_i[NW-1:CW];
  // quotient needs more than CW bits: saturate later
  assign ovf0   = NW'(num_hi) >= NW'(den_i);

  for (genvar s = 0; s < CW; s++) begin : g_step
    logic [CW:0] t;
    logic [CW:0] diff;
    logic        ge;
    always_comb begin
      t        = {rem_q[s], low_q[s][CW-1]};
      diff     = t - {1'b0, den_q[s]};
      ge       = t >= {1'b0, den_q[s]};
      rem_d[s] = ge ? diff[CW-1:0] : t[CW-1:0];
      quo_d[s] = {quo_q[s][CW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= ovf0 ? '0 : CW'(num_hi);
      low_q[0] <= num_i[CW-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      ovf_q[0] <= ovf0;
      neg_q[0] <= neg_i;
      for (int s = 0; s < CW; s++) begin
        rem_q[s+1] <= rem_d[s];
        low_q[s+1] <= low_q[s] << 1;
        quo_q[s+1] <= quo_d[s];
        den_q[s+1] <= den_q[s];
        ovf_q[s+1] <= ovf_q[s];
        neg_q[s+1] <= neg_q[s];
      end
    end
  end

  assign quo_o = quo_q[CW];
  assign ovf_o = ovf_q[CW];
  assign neg_o = neg_q[CW];

endmodule
`default_nettype wire

// File: hdl/homogeneous_point_transform_top.sv
`default_nettype none
// Channel  Direction  Handshake                  Payload
// cfg      in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
// in       in         in_valid_i / in_ready_o    kind_i, in_x_i, in_y_i, in_z_i
// out      out        out_valid_o / out_ready_i  out_x_o, out_y_o, out_z_o, divided_o,
//                                                saturated_o
//
// One transaction per cycle sustained while out_ready_i is high; the divider
// resolves one quotient bit per stage.
// Reset restores the identity matrix and empties the pipeline.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module homogeneous_point_transform_top
  import hpt_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [3:0]         cfg_index_i,
  input  wire logic [63:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         kind_i,
  input  wire logic signed [31:0] in_x_i,
  input  wire logic signed [31:0] in_y_i,
  input  wire logic signed [31:0] in_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      out_x_o,
  output logic signed [31:0]      out_y_o,
  output logic signed [31:0]      out_z_o,
  output logic                    divided_o,
  output logic                    saturated_o
);

  localparam int CW = COORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int D  = CW + 1;
  localparam logic signed [66:0] SUM_MAX = (67'sd1 <<< (CW - 1)) - 67'sd1;
  localparam logic signed [66:0] SUM_MIN = -SUM_MAX - 67'sd1;
  localparam logic signed [32:0] W_ONE   = 33'sd1 <<< F;
  localparam logic [CW:0]        Q_MAX   = (CW+1)'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic [CW:0]        Q_MIN   = (CW+1)'(64'd1 << (CW - 1));

  // ---------------- configuration ----------------
  logic [63:0] regs_q [NUM_REGS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[0] <= ROW0_XY_RST;
      regs_q[1] <= ROW0_ZW_RST;
      regs_q[2] <= ROW1_XY_RST;
      regs_q[3] <= ROW1_ZW_RST;
      regs_q[4] <= ROW2_XY_RST;
      regs_q[5] <= ROW2_ZW_RST;
      regs_q[6] <= ROW3_XY_RST;
      regs_q[7] <= ROW3_ZW_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ROW0_XY: regs_q[0] <= cfg_data_i;
        REG_ROW0_ZW: regs_q[1] <= cfg_data_i;
        REG_ROW1_XY: regs_q[2] <= cfg_data_i;
        REG_ROW1_ZW: regs_q[3] <= cfg_data_i;
        REG_ROW2_XY: regs_q[4] <= cfg_data_i;
        REG_ROW2_ZW: regs_q[5] <= cfg_data_i;
        REG_ROW3_XY: regs_q[6] <= cfg_data_i;
        REG_ROW3_ZW: regs_q[7] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic en;
  logic out_valid_q;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;

  // ---------------- stage 1: products ----------------
  coef_t m   [4][4];
  coef_t a   [4][4];
  coef_t p   [3];
  logic  pre, point;

  always_comb begin
    pre   = (kind_i == KIND_PRE_POINT) || (kind_i == KIND_PRE_VECTOR);
    point = (kind_i == KIND_POST_POINT) || (kind_i == KIND_PRE_POINT);
    p[0]  = in_x_i;
    p[1]  = in_y_i;
    p[2]  = in_z_i;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m[r][c] = c[0] ? regs_q[2*r + c/2][63:32] : regs_q[2*r + c/2][31:0];
      end
    end
    for (int i = 0; i < 4; i++) begin
      for (int c = 0; c < 4; c++) begin
        a[i][c] = pre ? m[c][i] : m[i][c];
      end
    end
  end

  logic  v1_q;
  prod_t prod_q [4][3];
  coef_t tr1_q  [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[i][c] <= a[i][c] * p[c];
        end
        tr1_q[i] <= point ? a[i][3] : '0;
      end
    end
  end

  // ---------------- stage 2: exact sums ----------------
  logic  v2_q;
  dot_t  sum_q [4];
  coef_t tr2_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sum_q[i] <= 66'(prod_q[i][0]) + 66'(prod_q[i][1]) + 66'(prod_q[i][2]);
        tr2_q[i] <= tr1_q[i];
      end
    end
  end

  // ---------------- stage 3: floor, translate, clamp ----------------
  logic signed [66:0]   tsum [4];
  logic signed [CW-1:0] clip [4];
  logic [3:0]           clip_sat;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      tsum[i] = 67'(sum_q[i] >>> F) + 67'(tr2_q[i]);
      if (tsum[i] > SUM_MAX) begin
        clip[i]     = CW'(SUM_MAX);
        clip_sat[i] = 1'b1;
      end else if (tsum[i] < SUM_MIN) begin
        clip[i]     = CW'(SUM_MIN);
        clip_sat[i] = 1'b1;
      end else begin
        clip[i]     = CW'(tsum[i]);
        clip_sat[i] = 1'b0;
      end
    end
  end

  logic                 v3_q;
  logic signed [CW-1:0] res3_q [4];
  logic                 sat3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      res3_q <= clip;
      sat3_q <= |clip_sat;
    end
  end

  // ---------------- stage 4+: divide by w ----------------
  logic signed [32:0] w_ext;
  logic               div_en;
  logic [CW-1:0]      w_mag;
  logic [CW:0]        w_neg_full;
  logic [CW-1:0]      r_mag [3];
  logic [CW:0]        r_neg_full [3];
  logic [CW+F-1:0]    num [3];

  always_comb begin
    w_ext      = 33'(res3_q[3]);
    div_en     = (w_ext != 33'sd0) && (w_ext != W_ONE);
    w_neg_full = -(CW+1)'(res3_q[3]);
    w_mag      = res3_q[3][CW-1] ? w_neg_full[CW-1:0] : res3_q[3];
    for (int i = 0; i < 3; i++) begin
      r_neg_full[i] = -(CW+1)'(res3_q[i]);
      r_mag[i]      = res3_q[i][CW-1] ? r_neg_full[i][CW-1:0] : res3_q[i];
      num[i]        = {r_mag[i], {F{1'b0}}};
    end
  end

  logic [CW-1:0] quo [3];
  logic          ovf [3];
  logic          qneg [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    hpt_div #(
      .CW (CW),
      .F  (F)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num[i]),
      .den_i (w_mag),
      .neg_i (res3_q[i][CW-1] ^ res3_q[3][CW-1]),
      .quo_o (quo[i]),
      .ovf_o (ovf[i]),
      .neg_o (qneg[i])
    );
  end

  // sideband travels alongside the divider stages
  logic                 sb_v_q   [D];
  logic signed [CW-1:0] sb_r_q   [D][3];
  logic                 sb_div_q [D];
  logic                 sb_sat_q [D];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_r_q[0]   <= res3_q[0:2];
      sb_div_q[0] <= div_en;
      sb_sat_q[0] <= sat3_q;
      for (int s = 1; s < D; s++) begin
        sb_r_q[s]   <= sb_r_q[s-1];
        sb_div_q[s] <= sb_div_q[s-1];
        sb_sat_q[s] <= sb_sat_q[s-1];
      end
    end
  end

  // ---------------- final: sign, clamp, select ----------------
  logic signed [CW-1:0] fin [3];
  logic [2:0]           fin_sat;
  logic [CW:0]          qlim [3];
  logic [CW:0]          qneg_full [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qlim[i]      = qneg[i] ? Q_MIN : Q_MAX;
      qneg_full[i] = -(CW+1)'(quo[i]);
      fin_sat[i]   = 1'b0;
      if (!sb_div_q[D-1]) begin
        fin[i] = sb_r_q[D-1][i];
      end else if (ovf[i] || ((CW+1)'(quo[i]) > qlim[i])) begin
        fin[i]     = qneg[i] ? CW'(SUM_MIN) : CW'(SUM_MAX);
        fin_sat[i] = 1'b1;
      end else begin
        fin[i] = qneg[i] ? qneg_full[i][CW-1:0] : quo[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_x_o     <= 32'(fin[0]);
      out_y_o     <= 32'(fin[1]);
      out_z_o     <= 32'(fin[2]);
      divided_o   <= sb_div_q[D-1];
      saturated_o <= sb_sat_q[D-1] || (|fin_sat);
    end
  end

  // ---------------- valid bits ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < D; s++) begin
        sb_v_q[s] <= 1'b0;
      end
    end else if (en) begin
      v1_q      <= in_valid_i;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      sb_v_q[0] <= v3_q;
      for (int s = 1; s < D; s++) begin
        sb_v_q[s] <= sb_v_q[s-1];
      end
      out_valid_q <= sb_v_q[D-1];
    end
  end

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`default_nettype none
module tb_top;
  import hpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC        = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 48;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               divided;
    logic               saturated;
  } xform_res_t;

  class xform_scoreboard;
    logic [63:0] matrix[NUM_REGS];
    xform_res_t  pending[$];
    int          errors;

    function new();
      matrix[REG_ROW0_XY] = ROW0_XY_RST;
      matrix[REG_ROW0_ZW] = ROW0_ZW_RST;
      matrix[REG_ROW1_XY] = ROW1_XY_RST;
      matrix[REG_ROW1_ZW] = ROW1_ZW_RST;
      matrix[REG_ROW2_XY] = ROW2_XY_RST;
      matrix[REG_ROW2_ZW] = ROW2_ZW_RST;
      matrix[REG_ROW3_XY] = ROW3_XY_RST;
      matrix[REG_ROW3_ZW] = ROW3_ZW_RST;
      errors = 0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [63:0] data);
      if (idx < NUM_REGS) matrix[idx] = data;
    endfunction

    function logic signed [31:0] coef(int r, int c);
      logic [63:0] word;
      word = matrix[r * 2 + c / 2];
      return (c % 2) ? word[63:32] : word[31:0];
    endfunction

    function logic signed [31:0] clamp32(logic signed [127:0] v, inout bit sat);
      if (v > 128'sd2147483647) begin
        sat = 1;
        return 32'h7fff_ffff;
      end
      if (v < -128'sd2147483648) begin
        sat = 1;
        return 32'h8000_0000;
      end
      return v[31:0];
    endfunction

    function logic signed [31:0] dot_row(int i, bit pre, bit point,
                                         logic signed [31:0] p[3], inout bit sat);
      logic signed [127:0] acc, m, v;
      acc = 0;
      for (int c = 0; c < 3; c++) begin
        m = pre ? coef(c, i) : coef(i, c);
        v = p[c];
        acc += m * v;
      end
      // floor division by 2^FRAC
      acc = acc >>> FRAC;
      if (point) begin
        m = pre ? coef(3, i) : coef(i, 3);
        acc += m;
      end
      return clamp32(acc, sat);
    endfunction

    function void note_input(logic [1:0] kind, logic signed [31:0] px,
                             logic signed [31:0] py, logic signed [31:0] pz);
      logic signed [31:0] p[3];
      logic signed [31:0] r[3];
      logic signed [31:0] w;
      logic signed [63:0] num, den;
      logic signed [127:0] q;
      bit sat, pre, point;
      xform_res_t e;
      sat = 0;
      pre = kind[0];
      point = !kind[1];
      p[0] = px; p[1] = py; p[2] = pz;
      for (int i = 0; i < 3; i++) r[i] = dot_row(i, pre, point, p, sat);
      w = dot_row(3, pre, point, p, sat);
      e.divided = (w != 0) && (w != (32'sd1 <<< FRAC));
      if (e.divided) begin
        for (int i = 0; i < 3; i++) begin
          num = r[i];
          num = num <<< FRAC;
          den = w;
          q = num / den;
          r[i] = clamp32(q, sat);
        end
      end
      e.x = r[0]; e.y = r[1]; e.z = r[2];
      e.saturated = sat;
      pending.push_back(e);
    endfunction

    function void check_result(xform_res_t a);
      xform_res_t e;
      if (pending.size() == 0) begin
        $error("result with nothing pending: x=%h y=%h z=%h", a.x, a.y, a.z);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.x !== e.x) begin
        $error("out_x expected %h actual %h", e.x, a.x); errors++;
      end
      if (a.y !== e.y) begin
        $error("out_y expected %h actual %h", e.y, a.y); errors++;
      end
      if (a.z !== e.z) begin
        $error("out_z expected %h actual %h", e.z, a.z); errors++;
      end
      if (a.divided !== e.divided) begin
        $error("divided expected %b actual %b", e.divided, a.divided); errors++;
      end
      if (a.saturated !== e.saturated) begin
        $error("saturated expected %b actual %b", e.saturated, a.saturated); errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [3:0]         cfg_index_i = '0;
  logic [63:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         kind_i = KIND_POST_POINT;
  logic signed [31:0] in_x_i = '0;
  logic signed [31:0] in_y_i = '0;
  logic signed [31:0] in_z_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] out_x_o, out_y_o, out_z_o;
  logic               divided_o, saturated_o;

  xform_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;

  homogeneous_point_transform_top u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .kind_i, .in_x_i, .in_y_i, .in_z_i,
    .out_valid_o, .out_ready_i, .out_x_o, .out_y_o, .out_z_o,
    .divided_o, .saturated_o
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    xform_res_t a;
    if (rst_ni && out_valid_o && out_ready_i) begin
      a.x = out_x_o; a.y = out_y_o; a.z = out_z_o;
      a.divided = divided_o; a.saturated = saturated_o;
      sb.check_result(a);
    end
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_cfg(logic [3:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Caller leaves valid high after acceptance; drop it only when idling.
  task automatic send_point(logic [1:0] kind, logic signed [31:0] px,
                            logic signed [31:0] py, logic signed [31:0] pz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    in_x_i <= px;
    in_y_i <= py;
    in_z_i <= pz;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(kind, px, py, pz);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coef(int style);
    case (style)
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return 32'h0;
      default: return $signed($urandom_range(8 << FRAC)) - (4 << FRAC);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(1)) return $urandom;
    return $signed($urandom_range(16 << FRAC)) - (8 << FRAC);
  endfunction

  task automatic load_matrix(int setting);
    logic [63:0] word;
    int style;
    for (int r = 0; r < 4; r++) begin
      for (int h = 0; h < 2; h++) begin
        style = (setting == 1) ? 1 : (setting == 2) ? 2 : $urandom_range(3);
        word = {rand_coef(style), rand_coef(style)};
        if (setting == 1 && r == 0) word = 64'h7fff_ffff_7fff_ffff;
        if (setting == 1 && r == 1) word = 64'h8000_0000_8000_0000;
        // keep the bottom row at 0 0 0 1 half the time so the no-divide path is exercised
        if (r == 3 && setting > 2 && setting % 2 == 0)
          word = (h == 0) ? 64'h0 : {32'h0001_0000, 32'h0};
        write_cfg(4'(r * 2 + h), word);
      end
    end
    // out-of-range index must be ignored
    write_cfg(4'(NUM_REGS + $urandom_range(NUM_REGS - 1)), {$urandom, $urandom});
  endtask

  initial begin
    logic signed [31:0] ext[5];
    logic [1:0] kinds[4];
    ext = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, 32'sh0001_0000, -32'sh0001_0000};
    kinds = '{KIND_POST_POINT, KIND_PRE_POINT, KIND_POST_VECTOR, KIND_PRE_VECTOR};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity matrix from reset: extremes through every kind
    foreach (kinds[k])
      for (int e = 0; e < 5; e++)
        send_point(kinds[k], ext[e], ext[(e + 1) % 5], ext[(e + 2) % 5]);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 82 : 6) : 0;
      recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 2) ? 82 : 6) : 0;
      load_matrix(ph == 0 ? 1 : ph == 1 ? 2 : ph + 2);
      for (int n = 0; n < 123; n++) begin
        if (ph == 5 && n == 60) drain();
        send_point($urandom_range(3), rand_coord(), rand_coord(), rand_coord());
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
